FILE: hw/rtl/hex_read_reply_checker_top_defines.svh
// Assertion macros for the checker file of the hex read reply checker.
`ifndef HEX_READ_REPLY_CHECKER_TOP_DEFINES_SVH
`define HEX_READ_REPLY_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HRRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrrc assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HRRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrrc assertion failed");

`endif

FILE: hw/rtl/hrrc_pkg.sv
// Package with the constants, status codes and hex decoding for the hex read reply checker.
package hrrc_pkg;

  localparam int unsigned FrameMax = 13;
  localparam int unsigned CountW   = 4;

  localparam logic [7:0] CharStx   = 8'h02;
  localparam logic [7:0] CharEtx   = 8'h03;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharGt    = 8'h3E;

  localparam logic [CountW-1:0] LenShort = 4'd11;
  localparam logic [CountW-1:0] LenLong  = 4'd13;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadFrame  = 2'd1,
    StNoReply   = 2'd2,
    StBadNumber = 2'd3
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hw/rtl/hex_read_reply_checker_top.sv
// Top level of the hex read reply checker: frame capture, frame check and hex parse.
//
//   channel  direction  tdata                              tlast         tuser
//   s_axis   in         [7:0] rx_byte, [22:8] exp. command end_of_reply  no_reply
//   m_axis   out        [15:0] value                       -             [1:0] status
//
// A new request is accepted in every cycle while the output register is empty or being drained.
// A reply result appears in the output register in the cycle after its last request is accepted.
// The output register holds a result until it is taken; requests are accepted
// meanwhile as long as the output register is empty or being drained.
// Reset clears the byte count and the output valid; stored bytes are not cleared.
module hex_read_reply_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] rx_byte, [22:8] expected_command, [23] zero
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,  // [0] no_reply
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] value
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  logic [hrrc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [7:0] store_q [hrrc_pkg::FrameMax];
  logic [7:0] eff [hrrc_pkg::FrameMax];
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_value_q, out_value_d;
  hrrc_pkg::status_e out_status_q, out_status_d;

  logic [7:0]  rx_byte;
  logic [14:0] cmd;
  logic        accept, room, reply_end;
  logic [hrrc_pkg::CountW-1:0] len;
  logic        len13, len_ok, fields_ok, etx_ok, sum_ok, frame_ok;
  logic [7:0]  x9, x11;
  hrrc_pkg::hex_t dig [4];
  logic [15:0] val;
  logic        any_digit, run;

  assign rx_byte   = s_axis_tdata_i[7:0];
  assign cmd       = s_axis_tdata_i[22:8];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign room      = cnt_q < 4'(hrrc_pkg::FrameMax);
  assign reply_end = s_axis_tlast_i || s_axis_tuser_i;

  always_comb begin
    for (int i = 0; i < hrrc_pkg::FrameMax; i++) begin
      eff[i] = (!s_axis_tuser_i && room && cnt_q == 4'(i)) ? rx_byte : store_q[i];
    end
  end

  always_comb begin
    if (s_axis_tuser_i || !room) begin
      len = cnt_q;
    end else begin
      len = cnt_q + 4'd1;
    end
  end

  always_comb begin
    len13  = len == hrrc_pkg::LenLong;
    len_ok = len13 || len == hrrc_pkg::LenShort;
    fields_ok = eff[0] == hrrc_pkg::CharStx &&
                eff[1] == {1'b0, cmd[14:8]} &&
                eff[2] == {1'b0, cmd[6:0]} &&
                eff[3] == hrrc_pkg::CharSpace;
    if (len13) begin
      fields_ok = fields_ok && eff[4] == hrrc_pkg::CharSpace &&
                  eff[5] == hrrc_pkg::CharSpace && eff[6] == hrrc_pkg::CharGt;
    end else begin
      fields_ok = fields_ok && eff[4] == hrrc_pkg::CharGt;
    end
    x9 = 8'd0;
    for (int i = 1; i <= 9; i++) begin
      x9 = x9 ^ eff[i];
    end
    x11 = x9 ^ eff[10] ^ eff[11];
    etx_ok = len13 ? (eff[11] == hrrc_pkg::CharEtx) : (eff[9] == hrrc_pkg::CharEtx);
    sum_ok = len13 ? (eff[12] == x11) : (eff[10] == x9);
    frame_ok = len_ok && fields_ok && etx_ok && sum_ok;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dig[i] = hrrc_pkg::hex_digit(len13 ? eff[7 + i] : eff[5 + i]);
    end
    val = 16'd0;
    run = 1'b1;
    for (int i = 0; i < 4; i++) begin
      run = run && dig[i].ok;
      if (run) begin
        val = {val[11:0], dig[i].val};
      end
    end
    any_digit = dig[0].ok;
  end

  always_comb begin
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    if (accept) begin
      if (reply_end) begin
        cnt_d       = '0;
        out_valid_d = 1'b1;
        out_value_d = 16'd0;
        if (len == '0) begin
          out_status_d = hrrc_pkg::StNoReply;
        end else if (!frame_ok) begin
          out_status_d = hrrc_pkg::StBadFrame;
        end else if (!any_digit) begin
          out_status_d = hrrc_pkg::StBadNumber;
        end else begin
          out_status_d = hrrc_pkg::StOk;
          out_value_d  = val;
        end
      end else if (room) begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    if (accept && !s_axis_tuser_i && room) begin
      store_q[cnt_q] <= rx_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

FILE: hw/rtl/hrrc_checker.sv
// Port-level assertion checker for the hex read reply checker and its bind statement.
`include "hex_read_reply_checker_top_defines.svh"

module hrrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic        s_axis_tlast_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_i,
  input logic [1:0]  m_axis_tuser_i
);

  logic end_req;
  logic not_ok;
  assign end_req = s_axis_tvalid_i && s_axis_tready_i && (s_axis_tlast_i || s_axis_tuser_i);
  assign not_ok  = m_axis_tuser_i != hrrc_pkg::StOk;

  `HRRC_ASSERT_NEXT(a_out_held, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i)
  `HRRC_ASSERT_NOW(a_value_zero, m_axis_tvalid_i && not_ok, m_axis_tdata_i == 16'd0)
  `HRRC_ASSERT_NEXT(a_end_gives_result, end_req, m_axis_tvalid_i)
  `HRRC_ASSERT_NOW(a_result_has_cause, $rose(m_axis_tvalid_i), $past(end_req))

endmodule

bind hex_read_reply_checker_top hrrc_checker u_hrrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
